[src/ccdpct_pkg.sv]
// Shared types, widths, register indexes and the exp2 root table for the
// pocket charge transfer block. No dependencies.
package ccdpct_pkg;

  // Charge words are Q20.8, log values are unsigned Q5.16.
  localparam int QW = 28;
  localparam int LW = 21;
  // Exponent accumulator, signed log domain Q.16.
  localparam int EW = 29;
  // Width of a flush or fill term.
  localparam int TW = 42;
  // Mantissa width, Q1.30.
  localparam int MW = 31;

  typedef enum logic [1:0] {
    REG_FLUSH_EXP = 2'd0,
    REG_FILL_EXP  = 2'd1,
    REG_CAPACITY  = 2'd2,
    REG_SCALE     = 2'd3
  } reg_index_t;

  // Operand for the log2 unit.
  typedef enum logic [2:0] {
    LOG_CAP    = 3'd0,
    LOG_POCKET = 3'd1,
    LOG_ROOM   = 3'd2,
    LOG_PIXEL  = 3'd3,
    LOG_SCALE  = 3'd4
  } log_sel_t;

  typedef struct packed {
    logic     accept;
    logic     log_start;
    log_sel_t log_sel;
    logic     save_lc;
    logic     save_ln;
    logic     mul_go;
    logic     mul_fill;
    logic     add_go;
    logic     add_from_lc;
    logic     e_init;
    logic     exp_start;
    logic     save_flush;
    logic     save_fill;
    logic     delta_go;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic log_done;
    logic exp_done;
    logic q_pos;
    logic n_neg;
    logic n_zero;
    logic q_ge_cap;
    logic fill_zero;
    logic out_free;
  } status_t;

  typedef logic [15:0][MW-1:0] root_tab_t;

  // Integer square root, used at elaboration only.
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'd1 << 62;
    x = v;
    for (int k = 0; k < 32; k++) begin
      if (b > x) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Entry j holds 2^(2^-(j+1)) in Q1.30, each taken as the root of the last.
  function automatic root_tab_t root_table();
    logic [63:0] prev;
    root_tab_t   t;
    prev = isqrt64(64'd1 << 61);
    t[0] = prev[MW-1:0];
    for (int j = 1; j < 16; j++) begin
      prev = isqrt64({prev[33:0], 30'd0});
      t[j] = prev[MW-1:0];
    end
    return t;
  endfunction

  localparam root_tab_t EXP_ROOT = root_table();

endpackage

[src/ccd_pocket_charge_transfer.sv]
// Top level of the pocket charge transfer block: controller plus datapath.
// Depends on ccdpct_pkg, ccdpct_ctrl and ccdpct_dp.

// Corrects one pixel charge per request (Q20.8) against a stored pocket
// charge: the result is pixel + flush - fill, saturated, and the pocket is
// updated to max(0, pocket - delta). A request with line_start set clears the
// pocket first. Requests are worked one at a time; the time a request takes
// depends on its values, set by the single shared log2 unit (up to five
// calls) and the exp2 unit (up to two calls). The next request is taken
// while the previous result waits in the output register. Configuration
// writes are expected only while no request is in progress.
module ccd_pocket_charge_transfer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [1:0]                       cfg_index,
  input  logic [ccdpct_pkg::QW-1:0]         cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [ccdpct_pkg::QW-1:0]  pixel_charge,
  input  logic                             line_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ccdpct_pkg::QW-1:0]  corrected_charge,
  output logic                             saturated
);
  import ccdpct_pkg::*;

  cmd_t    cmd;
  status_t status;

  ccdpct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ccdpct_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pixel_charge     (pixel_charge),
    .line_start       (line_start),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .corrected_charge (corrected_charge),
    .saturated        (saturated)
  );

`ifndef SYNTHESIS
  // One request in flight: stall right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in progress");

  // A result only appears at the end of a request
  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in progress");

  // Finishing a request always leaves a result behind
  a_done_has_result: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> out_valid)
    else $error("request finished without a result");
`endif

endmodule

[src/ccdpct_log2.sv]
// Iterative log2 unit: five normalizing shift steps, then sixteen mantissa
// squaring steps. Depends on ccdpct_pkg.
module ccdpct_log2 (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ccdpct_pkg::QW-1:0] value,
  output logic                     done,
  output logic [ccdpct_pkg::LW-1:0] result
);
  import ccdpct_pkg::*;

  logic          busy;
  logic [4:0]    cnt;
  logic [MW-1:0] m;
  logic [4:0]    p;
  logic [15:0]   frac;
  logic [61:0]   sq;

  assign sq     = {31'd0, m} * {31'd0, m};
  assign result = {p, frac};

  // Normalize, then square and take one fraction bit per step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        m    <= {3'd0, value};
        p    <= 5'd30;
        frac <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        unique case (cnt)
          5'd0: if (m[30:15] == '0) begin m <= m << 16; p <= p - 5'd16; end
          5'd1: if (m[30:23] == '0) begin m <= m << 8;  p <= p - 5'd8;  end
          5'd2: if (m[30:27] == '0) begin m <= m << 4;  p <= p - 5'd4;  end
          5'd3: if (m[30:29] == '0) begin m <= m << 2;  p <= p - 5'd2;  end
          5'd4: if (!m[30])         begin m <= m << 1;  p <= p - 5'd1;  end
          default: begin
            frac <= {frac[14:0], sq[61]};
            m    <= sq[61] ? sq[61:31] : sq[60:30];
          end
        endcase
        if (cnt == 5'd20) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/ccdpct_exp2.sv]
// Iterative exp2 unit: one root multiply per fraction bit, then a final
// scaling shift. Depends on ccdpct_pkg.
module ccdpct_exp2 (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [ccdpct_pkg::EW-1:0] e,
  output logic                            done,
  output logic [ccdpct_pkg::TW-1:0]        result
);
  import ccdpct_pkg::*;

  logic               busy;
  logic               shift_ph;
  logic [3:0]         cnt;
  logic [MW-1:0]      m;
  logic [15:0]        f;
  logic signed [12:0] ipart;
  logic signed [12:0] e_int;
  logic signed [7:0]  sh;
  logic [3:0]         ridx;
  logic [61:0]        prod;
  logic [5:0]         rsh;

  assign e_int = e[EW-1:16];
  assign ridx  = 4'd15 - cnt;
  assign prod  = {31'd0, m} * {31'd0, EXP_ROOT[ridx]};
  assign sh    = 8'(ipart) - 8'sd30;
  assign rsh   = 6'(-sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      shift_ph <= 1'b0;
      done     <= 1'b0;
      cnt      <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ipart <= e_int;
        f     <= e[15:0];
        m     <= MW'(1) << 30;
        cnt   <= 4'd15;
        // Clip huge terms, drop tiny ones
        if (e_int >= 13'sd41) begin
          result <= '1;
          done   <= 1'b1;
        end else if (e_int < -13'sd40) begin
          result <= '0;
          done   <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (f[cnt]) m <= prod[60:30];
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          busy     <= 1'b0;
          shift_ph <= 1'b1;
        end
      end else if (shift_ph) begin
        // Scale the mantissa by 2^(i-30)
        shift_ph <= 1'b0;
        done     <= 1'b1;
        if (sh >= 8'sd0) result <= {11'd0, m} << sh[3:0];
        else if (sh <= -8'sd40) result <= '0;
        else result <= {11'd0, m} >> rsh;
      end
    end
  end

endmodule

[src/ccdpct_dp.sv]
// Datapath: configuration registers, pocket state, log2 and exp2 units,
// exponent scaling multiplier and the output stage. Depends on ccdpct_pkg.
module ccdpct_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [1:0]                       cfg_index,
  input  logic [ccdpct_pkg::QW-1:0]         cfg_data,
  input  logic signed [ccdpct_pkg::QW-1:0]  pixel_charge,
  input  logic                             line_start,
  input  ccdpct_pkg::cmd_t                 cmd,
  output ccdpct_pkg::status_t              status,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ccdpct_pkg::QW-1:0]  corrected_charge,
  output logic                             saturated
);
  import ccdpct_pkg::*;

  logic [15:0]          flush_exp;
  logic [15:0]          fill_exp;
  logic [QW-1:0]        capacity;
  logic [QW-1:0]        scale;
  logic [QW-1:0]        pocket;
  logic signed [QW-1:0] n;
  logic [QW-1:0]        q;
  logic [LW-1:0]        lc;
  logic [LW-1:0]        ln;
  logic signed [38:0]   prod;
  logic signed [EW-1:0] eacc;
  logic signed [EW-1:0] eacc_next;
  logic [TW-1:0]        flush;
  logic [TW-1:0]        fill;
  logic signed [TW:0]   delta;

  logic [QW-1:0]        cap_eff;
  logic [QW-1:0]        scale_eff;
  logic [QW-1:0]        log_in;
  logic [LW-1:0]        lg;
  logic                 lg_done;
  logic [TW-1:0]        ex;
  logic                 ex_done;
  logic signed [LW:0]   diff;
  logic signed [38:0]   prod_next;
  logic signed [EW-1:0] s_ext;
  logic signed [43:0]   res;
  logic signed [43:0]   pk;
  logic                 res_hi;
  logic                 res_lo;
  logic                 pk_hi;

  assign cap_eff   = (capacity == '0) ? QW'(1) : capacity;
  assign scale_eff = (scale == '0) ? QW'(1) : scale;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      flush_exp <= 16'd4096;
      fill_exp  <= 16'd4096;
      capacity  <= QW'(256000);
      scale     <= QW'(256000);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_FLUSH_EXP: flush_exp <= cfg_data[15:0];
        REG_FILL_EXP:  fill_exp  <= cfg_data[15:0];
        REG_CAPACITY:  capacity  <= cfg_data;
        REG_SCALE:     scale     <= cfg_data;
      endcase
    end
  end

  // Select the log2 operand
  always_comb begin
    unique case (cmd.log_sel)
      LOG_CAP:    log_in = cap_eff;
      LOG_POCKET: log_in = q;
      LOG_ROOM:   log_in = cap_eff - q;
      LOG_PIXEL:  log_in = n;
      LOG_SCALE:  log_in = scale_eff;
      default:    log_in = cap_eff;
    endcase
  end

  ccdpct_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.log_start),
    .value  (log_in),
    .done   (lg_done),
    .result (lg)
  );

  // Exponent times log difference, then back to Q.16 with floor
  always_comb begin
    if (cmd.mul_fill) diff = $signed({1'b0, ln}) - $signed({1'b0, lg});
    else              diff = $signed({1'b0, lg}) - $signed({1'b0, lc});
    prod_next = diff * $signed({1'b0, (cmd.mul_fill ? fill_exp : flush_exp)});
    s_ext     = {{2{prod[38]}}, prod[38:12]};
    if (cmd.e_init)      eacc_next = $signed({8'd0, lc});
    else if (cmd.add_go) eacc_next = (cmd.add_from_lc ? $signed({8'd0, lc}) : eacc) + s_ext;
    else                 eacc_next = eacc;
  end

  ccdpct_exp2 u_exp2 (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.exp_start),
    .e      (eacc_next),
    .done   (ex_done),
    .result (ex)
  );

  // Latch the request and hold the intermediate values
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      n     <= pixel_charge;
      q     <= line_start ? '0 : pocket;
      flush <= '0;
      fill  <= '0;
    end
    if (cmd.save_lc)    lc    <= lg;
    if (cmd.save_ln)    ln    <= lg;
    if (cmd.mul_go)     prod  <= prod_next;
    eacc <= eacc_next;
    if (cmd.save_flush) flush <= ex;
    if (cmd.save_fill)  fill  <= ex;
    if (cmd.delta_go)   delta <= $signed({1'b0, flush}) - $signed({1'b0, fill});
  end

  // Corrected charge and next pocket, with clipping
  always_comb begin
    res    = 44'(n) + 44'(delta);
    pk     = $signed({16'd0, q}) - 44'(delta);
    res_hi = !res[43] && (res[42:27] != '0);
    res_lo = res[43] && (res[42:27] != '1);
    pk_hi  = !pk[43] && (pk[42:28] != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pocket    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        if (pk[43])     pocket <= '0;
        else if (pk_hi) pocket <= '1;
        else            pocket <= pk[QW-1:0];
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (res_hi)      corrected_charge <= {1'b0, {(QW-1){1'b1}}};
      else if (res_lo) corrected_charge <= {1'b1, {(QW-1){1'b0}}};
      else             corrected_charge <= res[QW-1:0];
      saturated <= res_hi || res_lo || pk_hi;
    end
  end

  // Status toward the controller
  always_comb begin
    status.log_done  = lg_done;
    status.exp_done  = ex_done;
    status.q_pos     = (q != '0);
    status.n_neg     = n[QW-1];
    status.n_zero    = (n == '0);
    status.q_ge_cap  = (q >= cap_eff);
    status.fill_zero = ((q >= cap_eff) && (flush_exp != '0))
                     || ((n == '0) && (fill_exp != '0));
    status.out_free  = !out_valid || !out_stall;
  end

endmodule

[src/ccdpct_ctrl.sv]
// Controller: sequences the log2, multiply, add and exp2 steps for one
// request at a time. Depends on ccdpct_pkg.
module ccdpct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ccdpct_pkg::status_t status,
  output ccdpct_pkg::cmd_t    cmd
);
  import ccdpct_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE  = 18'b000000000000000001,
    S_LOG_C = 18'b000000000000000010,
    S_LOG_Q = 18'b000000000000000100,
    S_MUL_Q = 18'b000000000000001000,
    S_ADD_Q = 18'b000000000000010000,
    S_EXP_F = 18'b000000000000100000,
    S_FILL  = 18'b000000000001000000,
    S_LOG_R = 18'b000000000010000000,
    S_MUL_R = 18'b000000000100000000,
    S_ADD_R = 18'b000000001000000000,
    S_NPIX  = 18'b000000010000000000,
    S_LOG_N = 18'b000000100000000000,
    S_LOG_M = 18'b000001000000000000,
    S_MUL_N = 18'b000010000000000000,
    S_ADD_N = 18'b000100000000000000,
    S_EXP_L = 18'b001000000000000000,
    S_DELTA = 18'b010000000000000000,
    S_FIN   = 18'b100000000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.log_sel = LOG_CAP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept    = 1'b1;
          cmd.log_start = 1'b1;
          state_next    = S_LOG_C;
        end
      end
      S_LOG_C: begin
        if (status.log_done) begin
          cmd.save_lc = 1'b1;
          if (status.q_pos) begin
            cmd.log_start = 1'b1;
            cmd.log_sel   = LOG_POCKET;
            state_next    = S_LOG_Q;
          end else begin
            state_next = S_FILL;
          end
        end
      end
      S_LOG_Q: if (status.log_done) state_next = S_MUL_Q;
      S_MUL_Q: begin
        cmd.mul_go = 1'b1;
        state_next = S_ADD_Q;
      end
      S_ADD_Q: begin
        cmd.add_go      = 1'b1;
        cmd.add_from_lc = 1'b1;
        cmd.exp_start   = 1'b1;
        state_next      = S_EXP_F;
      end
      S_EXP_F: begin
        if (status.exp_done) begin
          cmd.save_flush = 1'b1;
          state_next     = S_FILL;
        end
      end
      // Fill term: skip for negative pixels or a zero fill, skip the room log when full
      S_FILL: begin
        if (status.n_neg || status.fill_zero) begin
          state_next = S_DELTA;
        end else begin
          cmd.e_init = 1'b1;
          if (status.q_ge_cap) begin
            state_next = S_NPIX;
          end else begin
            cmd.log_start = 1'b1;
            cmd.log_sel   = LOG_ROOM;
            state_next    = S_LOG_R;
          end
        end
      end
      S_LOG_R: if (status.log_done) state_next = S_MUL_R;
      S_MUL_R: begin
        cmd.mul_go = 1'b1;
        state_next = S_ADD_R;
      end
      S_ADD_R: begin
        cmd.add_go = 1'b1;
        state_next = S_NPIX;
      end
      S_NPIX: begin
        if (status.n_zero) begin
          cmd.exp_start = 1'b1;
          state_next    = S_EXP_L;
        end else begin
          cmd.log_start = 1'b1;
          cmd.log_sel   = LOG_PIXEL;
          state_next    = S_LOG_N;
        end
      end
      S_LOG_N: begin
        if (status.log_done) begin
          cmd.save_ln   = 1'b1;
          cmd.log_start = 1'b1;
          cmd.log_sel   = LOG_SCALE;
          state_next    = S_LOG_M;
        end
      end
      S_LOG_M: if (status.log_done) state_next = S_MUL_N;
      S_MUL_N: begin
        cmd.mul_go   = 1'b1;
        cmd.mul_fill = 1'b1;
        state_next   = S_ADD_N;
      end
      S_ADD_N: begin
        cmd.add_go    = 1'b1;
        cmd.exp_start = 1'b1;
        state_next    = S_EXP_L;
      end
      S_EXP_L: begin
        if (status.exp_done) begin
          cmd.save_fill = 1'b1;
          state_next    = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd.delta_go = 1'b1;
        state_next   = S_FIN;
      end
      // Hold until the output register is free
      S_FIN: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
